### hw/rtl/iqmp_pkg.sv
package iqmp_pkg;

   // Number of CORDIC micro-rotations; at most 32 are ever made.
   localparam int ANGLE_ITERATIONS = 16;
   localparam int CORDIC_STEPS     = (ANGLE_ITERATIONS > 32) ? 32 : ANGLE_ITERATIONS;

   localparam int IN_W     = 32;
   localparam int MAG_W    = 32;
   localparam int PHASE_W  = 16;
   localparam int ACC_W    = 32;
   localparam int CORDIC_W = 35;
   localparam int ROOT_W   = 32;
   localparam int RAD_W    = 2 * ROOT_W;
   localparam int REM_W    = ROOT_W + 1;

   // Stage 0 input, 1 absolute values and CORDIC setup, 2 squares, 3 sum,
   // then one square-root bit per stage, then the output register.
   localparam int SQRT_FIRST = 4;
   localparam int LAST_STAGE = SQRT_FIRST + ROOT_W;

   // round(atan(2^-i) * 2^31 / pi), 2^32 units per full turn.
   localparam logic [ACC_W-1:0] STEP_ANGLE [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   localparam logic [ACC_W-1:0] HALF_TURN   = 32'h8000_0000;
   localparam logic [ACC_W-1:0] PHASE_ROUND = 32'h0000_8000;
   localparam logic [MAG_W-1:0] MAG_MAX     = 32'd3037000500;

endpackage

### hw/rtl/iq_to_magnitude_phase.sv
// Channel   Ports                                   Direction  Handshake
// request   req_in_phase, req_quadrature            in         req_valid / req_stall
// response  rsp_magnitude, rsp_phase_angle          out        rsp_valid / rsp_stall
//
// One item enters per cycle and one result leaves per cycle when nothing stalls.
// The magnitude path sets the depth: one stage per square-root bit (32 stages)
// behind the abs, square and sum stages. Reset is synchronous and clears the
// valid bits and the skid full flag only. A stalled result freezes the whole
// pipeline; the skid register still takes one more item, so req_stall rises
// in the cycle after that item is taken and falls in the cycle after the freeze ends.
module iq_to_magnitude_phase (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [iqmp_pkg::IN_W-1:0]     req_in_phase,
   input  logic signed [iqmp_pkg::IN_W-1:0]     req_quadrature,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic        [iqmp_pkg::MAG_W-1:0]    rsp_magnitude,
   output logic signed [iqmp_pkg::PHASE_W-1:0]  rsp_phase_angle
);
   import iqmp_pkg::*;

   // The whole pipeline moves together unless the output holds an untaken result.
   logic pipe_en;
   logic req_take;

   logic                    skid_full_ff, skid_full_in;
   logic signed [IN_W-1:0]  skid_i_ff, skid_q_ff;

   logic [LAST_STAGE:0]     v_ff, v_in;

   logic signed [IN_W-1:0]  s0_i_ff, s0_q_ff;

   // Magnitude path.
   logic [IN_W-1:0]         ai_ff, aq_ff, ai_in, aq_in;
   logic [RAD_W-1:0]        sqi_ff, sqq_ff;
   logic [RAD_W-1:0]        rad_ff  [3:LAST_STAGE-2];
   logic [ROOT_W-1:0]       root_ff [SQRT_FIRST:LAST_STAGE-1];
   logic [REM_W-1:0]        rem_ff  [SQRT_FIRST:LAST_STAGE-1];

   // Phase path: x and y live only as long as rotations remain. The last rotation
   // needs only the sign of y, so x stops one stage earlier.
   logic signed [CORDIC_W-1:0] cx_ff [1:CORDIC_STEPS-1];
   logic signed [CORDIC_W-1:0] cy_ff [1:CORDIC_STEPS];
   logic [ACC_W-1:0]           acc_ff [1:LAST_STAGE-1];
   logic                       nz_ff  [1:LAST_STAGE-1];
   logic signed [CORDIC_W-1:0] cx1_in, cy1_in, xi, yi;
   logic [ACC_W-1:0]           acc1_in;

   logic [MAG_W-1:0]           out_mag_ff, out_mag_in;
   logic signed [PHASE_W-1:0]  out_phase_ff, out_phase_in;
   logic [ACC_W-1:0]           phase_sum;

   assign pipe_en   = !(v_ff[LAST_STAGE] && rsp_stall);
   assign req_take  = req_valid && !skid_full_ff;
   assign req_stall = skid_full_ff;

   // The skid register catches the item taken in the cycle the pipeline freezes.
   always_comb begin
      skid_full_in = skid_full_ff;
      if (pipe_en) begin
         skid_full_in = 1'b0;
      end else if (req_take) begin
         skid_full_in = 1'b1;
      end
   end

   always_comb begin
      v_in[0] = skid_full_ff || req_valid;
      for (int k = 1; k <= LAST_STAGE; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
         v_ff         <= '0;
      end else begin
         skid_full_ff <= skid_full_in;
         if (pipe_en) begin
            v_ff <= v_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!pipe_en && req_take) begin
         skid_i_ff <= req_in_phase;
         skid_q_ff <= req_quadrature;
      end
      if (pipe_en) begin
         s0_i_ff <= skid_full_ff ? skid_i_ff : req_in_phase;
         s0_q_ff <= skid_full_ff ? skid_q_ff : req_quadrature;
      end
   end

   // Stage 1: absolute values for the magnitude, and the CORDIC start point.
   // A vector in the left half-plane is turned by half a turn first.
   always_comb begin
      ai_in   = s0_i_ff[IN_W-1] ? IN_W'(~s0_i_ff + 1'b1) : IN_W'(s0_i_ff);
      aq_in   = s0_q_ff[IN_W-1] ? IN_W'(~s0_q_ff + 1'b1) : IN_W'(s0_q_ff);
      xi      = CORDIC_W'(s0_i_ff);
      yi      = CORDIC_W'(s0_q_ff);
      cx1_in  = s0_i_ff[IN_W-1] ? -xi : xi;
      cy1_in  = s0_i_ff[IN_W-1] ? -yi : yi;
      acc1_in = s0_i_ff[IN_W-1] ? HALF_TURN : '0;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ai_ff     <= ai_in;
         aq_ff     <= aq_in;
         cx_ff[1]  <= cx1_in;
         cy_ff[1]  <= cy1_in;
         acc_ff[1] <= acc1_in;
         nz_ff[1]  <= (|s0_i_ff) || (|s0_q_ff);
      end
   end

   // Stages 2 and 3: the two squares, then their sum.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sqi_ff    <= RAD_W'(ai_ff) * RAD_W'(ai_ff);
         sqq_ff    <= RAD_W'(aq_ff) * RAD_W'(aq_ff);
         rad_ff[3] <= sqi_ff + sqq_ff;
      end
   end

   for (genvar s = 4; s <= LAST_STAGE - 2; s++) begin : g_rad
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            rad_ff[s] <= rad_ff[s-1];
         end
      end
   end

   // Restoring square root, one result bit per stage, two radicand bits consumed each.
   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      localparam int S = SQRT_FIRST + j;
      logic [ROOT_W-1:0] root_prev, root_in;
      logic [REM_W-1:0]  rem_prev, rem_in;
      logic [REM_W+1:0]  shifted, trial, diff;
      logic              fits;

      if (j == 0) begin : g_first
         assign root_prev = '0;
         assign rem_prev  = '0;
      end else begin : g_next
         assign root_prev = root_ff[S-1];
         assign rem_prev  = rem_ff[S-1];
      end

      assign shifted = {rem_prev, rad_ff[S-1][RAD_W-1-2*j -: 2]};
      assign trial   = {1'b0, root_prev, 2'b01};
      assign diff    = shifted - trial;
      assign fits    = shifted >= trial;
      assign root_in = {root_prev[ROOT_W-2:0], fits};
      assign rem_in  = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            root_ff[S] <= root_in;
            rem_ff[S]  <= rem_in;
         end
      end
   end

   // CORDIC vectoring: one micro-rotation per stage, then the angle rides along.
   for (genvar s = 2; s <= LAST_STAGE - 1; s++) begin : g_cordic
      if (s <= CORDIC_STEPS + 1) begin : g_rot
         localparam int K = s - 2;
         logic [ACC_W-1:0]           acc_in;
         logic                       neg;

         assign neg = cy_ff[s-1][CORDIC_W-1];

         always_comb begin
            if (neg) begin
               acc_in = acc_ff[s-1] - STEP_ANGLE[K];
            end else begin
               acc_in = acc_ff[s-1] + STEP_ANGLE[K];
            end
         end

         always_ff @(posedge clock) begin
            if (pipe_en) begin
               acc_ff[s] <= acc_in;
               nz_ff[s]  <= nz_ff[s-1];
            end
         end

         if (s <= CORDIC_STEPS) begin : g_y
            logic signed [CORDIC_W-1:0] dx, cy_in;

            assign dx    = cx_ff[s-1] >>> K;
            assign cy_in = neg ? cy_ff[s-1] + dx : cy_ff[s-1] - dx;

            always_ff @(posedge clock) begin
               if (pipe_en) begin
                  cy_ff[s] <= cy_in;
               end
            end
         end

         if (s < CORDIC_STEPS) begin : g_x
            logic signed [CORDIC_W-1:0] dy, cx_in;

            assign dy    = cy_ff[s-1] >>> K;
            assign cx_in = neg ? cx_ff[s-1] - dy : cx_ff[s-1] + dy;

            always_ff @(posedge clock) begin
               if (pipe_en) begin
                  cx_ff[s] <= cx_in;
               end
            end
         end
      end else begin : g_hold
         always_ff @(posedge clock) begin
            if (pipe_en) begin
               acc_ff[s] <= acc_ff[s-1];
               nz_ff[s]  <= nz_ff[s-1];
            end
         end
      end
   end

   // Output stage: round the root to nearest (remainder above root means round up)
   // and round the angle to 16 bits, half up, wrapping at plus 180 degrees (0 at origin).
   always_comb begin
      out_mag_in   = MAG_W'(root_ff[LAST_STAGE-1])
                   + MAG_W'(rem_ff[LAST_STAGE-1] > REM_W'(root_ff[LAST_STAGE-1]));
      phase_sum    = acc_ff[LAST_STAGE-1] + PHASE_ROUND;
      out_phase_in = nz_ff[LAST_STAGE-1] ? PHASE_W'(phase_sum[ACC_W-1 -: PHASE_W]) : '0;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         out_mag_ff   <= out_mag_in;
         out_phase_ff <= out_phase_in;
      end
   end

   assign rsp_valid       = v_ff[LAST_STAGE];
   assign rsp_magnitude   = out_mag_ff;
   assign rsp_phase_angle = out_phase_ff;

endmodule

### hw/rtl/iqmp_checker.sv
module iqmp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic signed [iqmp_pkg::IN_W-1:0]     req_in_phase,
   input logic signed [iqmp_pkg::IN_W-1:0]     req_quadrature,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic        [iqmp_pkg::MAG_W-1:0]    rsp_magnitude,
   input logic signed [iqmp_pkg::PHASE_W-1:0]  rsp_phase_angle
);
   import iqmp_pkg::*;

   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_magnitude)
                                 && $stable(rsp_phase_angle))
      else $error("stalled result changed");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_magnitude <= MAG_MAX)
      else $error("magnitude out of range");

   // The input stalls only after it took an item while the output was held.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid) && $past(rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // Once the output moves again, the held item drains and the input stall clears in the next cycle.
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      req_stall && !(rsp_valid && rsp_stall) |=> !req_stall)
      else $error("input stall did not clear");

endmodule

bind iq_to_magnitude_phase iqmp_checker u_iqmp_checker (.*);

### verif/tb_iq_to_magnitude_phase.sv
`timescale 1ns / 1ps

module tb_iq_to_magnitude_phase;

   // The drain wait after the last result is longer than the time from a taken
   // item to its result. The watchdog gives up only after a stretch with no item
   // moving on either channel that no correct run can come near.
   localparam int DRAIN_CYCLES = 60;
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1275;
   localparam int IDLE_PCT     = 16;

   // The CORDIC never makes more than 32 micro-rotations.
   localparam int ROTATIONS =
      (iqmp_pkg::ANGLE_ITERATIONS > 32) ? 32 : iqmp_pkg::ANGLE_ITERATIONS;

   // These are the micro-rotation angles, round(atan(2^-k) * 2^31 / pi).
   // A full turn is 2^32 units.
   localparam logic [31:0] ATAN_STEP [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef struct {
      logic signed [iqmp_pkg::IN_W-1:0] in_phase;
      logic signed [iqmp_pkg::IN_W-1:0] quadrature;
   } iq_sample_type;

   typedef struct {
      logic        [iqmp_pkg::MAG_W-1:0]   magnitude;
      logic signed [iqmp_pkg::PHASE_W-1:0] phase_angle;
   } polar_type;

   // These are the shapes of random sample pairs. Each one stresses a different
   // part of the block.
   typedef enum {FULL_RANGE, NEAR_ORIGIN, SCALED_DOWN, ON_RAIL} sample_kind_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic signed [iqmp_pkg::IN_W-1:0]     req_in_phase = '0;
   logic signed [iqmp_pkg::IN_W-1:0]     req_quadrature = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic        [iqmp_pkg::MAG_W-1:0]    rsp_magnitude;
   logic signed [iqmp_pkg::PHASE_W-1:0]  rsp_phase_angle;

   iq_sample_type samples_to_send [$];
   polar_type     polar_due [$];
   logic          req_taken = 1'b0;
   int            items_sent = 0;
   int            items_accepted = 0;
   int            mismatches = 0;
   int            quiet_cycles = 0;

   iq_to_magnitude_phase uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_phase    (req_in_phase),
      .req_quadrature  (req_quadrature),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_magnitude   (rsp_magnitude),
      .rsp_phase_angle (rsp_phase_angle)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // This function gives the polar form of one sample pair. The magnitude is the
   // square root of I^2 + Q^2, taken bit by bit and rounded to nearest. The phase
   // comes from a vectoring CORDIC. Its shifts are arithmetic, so they round
   // toward minus infinity. Its angle accumulator is a 32-bit word that wraps.
   function automatic polar_type to_polar(logic signed [31:0] i_val,
                                          logic signed [31:0] q_val);
      longint      x;
      longint      y;
      longint      dx;
      longint      dy;
      logic [63:0] abs_i;
      logic [63:0] abs_q;
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] probe;
      logic [31:0] acc;
      polar_type   res;
      x = i_val;
      y = q_val;
      abs_i = (x < 0) ? -x : x;
      abs_q = (y < 0) ? -y : y;
      // The sum of squares reaches 2^63 at most, so it fits an unsigned 64-bit word.
      rem = abs_i * abs_i + abs_q * abs_q;
      root = '0;
      probe = 64'd1 << 62;
      while (probe > rem)
         probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      // The remainder now holds n - root^2. Round up when n is past root^2 + root.
      if (rem > root)
         root = root + 1;
      res.magnitude = root[31:0];

      acc = '0;
      if (x != 0 || y != 0) begin
         // The left half plane is folded over by a half turn before rotating.
         if (x < 0) begin
            x = -x;
            y = -y;
            acc = 32'h8000_0000;
         end
         for (int k = 0; k < ROTATIONS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               acc = acc + ATAN_STEP[k];
            end else begin
               x = x - dx;
               y = y + dy;
               acc = acc - ATAN_STEP[k];
            end
         end
         // Round half up to 16 bits. Plus 180 degrees wraps to -32768.
         acc = acc + 32'h0000_8000;
      end
      res.phase_angle = acc[31:16];
      return res;
   endfunction

   function automatic void queue_sample(logic signed [31:0] i_val, logic signed [31:0] q_val);
      iq_sample_type s;
      s.in_phase = i_val;
      s.quadrature = q_val;
      samples_to_send.push_back(s);
   endfunction

   // The driver works on the falling edge. A new item goes out only when no item
   // is offered or the offered one was taken at the last rising edge. A stalled
   // item is held exactly as it is. Both sides idle at random, except during a
   // window of the run where every cycle is used.
   always @(negedge clock) begin : drive_samples
      bit            steady;
      iq_sample_type s;
      steady = (items_sent >= 500 && items_sent < 850);
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (samples_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            s = samples_to_send.pop_front();
            req_in_phase <= s.in_phase;
            req_quadrature <= s.quadrature;
            req_valid <= 1'b1;
            items_sent++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The monitor works on the rising edge. An accepted item adds its prediction
   // to the back of the queue. An accepted result is checked against the oldest
   // prediction. Every item passes through the whole pipeline, so an item accepted
   // on this edge can never be the one whose result comes out on the same edge.
   always @(posedge clock) begin : watch_channels
      polar_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            polar_due.push_back(to_polar(req_in_phase, req_quadrature));
            items_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (polar_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with nothing expected: magnitude %0d phase %0d",
                           $realtime, rsp_magnitude, rsp_phase_angle);
            end else begin
               want = polar_due.pop_front();
               if (rsp_magnitude !== want.magnitude
                   || rsp_phase_angle !== want.phase_angle) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: expected magnitude %0d phase %0d, got magnitude %0d phase %0d",
                              $realtime, want.magnitude, want.phase_angle,
                              rsp_magnitude, rsp_phase_angle);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic signed [31:0] ip;
      logic signed [31:0] qd;
      logic signed [31:0] rail;
      sample_kind_type    kind;
      int                 total;

      // The directed pairs come first: the origin, the rails of both components in
      // every quadrant, and the negative real axis, where the phase wraps to -32768.
      // The largest magnitude comes from both components at the most negative value.
      queue_sample(0, 0);
      queue_sample(32'sh7fff_ffff, 0);
      queue_sample(32'sh8000_0000, 0);
      queue_sample(0, 32'sh7fff_ffff);
      queue_sample(0, 32'sh8000_0000);
      queue_sample(32'sh8000_0000, 32'sh8000_0000);
      queue_sample(32'sh7fff_ffff, 32'sh7fff_ffff);
      queue_sample(32'sh8000_0000, 32'sh7fff_ffff);
      queue_sample(32'sh7fff_ffff, 32'sh8000_0000);
      queue_sample(-1, 0);
      queue_sample(-5, 0);
      queue_sample(1, 0);
      queue_sample(0, 1);
      queue_sample(0, -1);
      queue_sample(1, 1);
      queue_sample(-1, -1);
      queue_sample(1, -1);
      queue_sample(-1, 1);
      queue_sample(3, 4);
      queue_sample(-3, 4);
      queue_sample(3, -4);
      queue_sample(-3, -4);
      queue_sample(32'sh8000_0000, 1);
      queue_sample(32'sh8000_0000, -1);

      // The random part mixes four shapes. Full-range words set every bit both
      // ways. Pairs near the origin work the rounding of small roots and the
      // coarse angles. Arithmetic right shifts spread the magnitudes over all
      // scales. Pairs on a rail pin one component at zero or at an extreme.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         kind = sample_kind_type'($urandom_range(3));
         case (kind)
            FULL_RANGE: begin
               ip = $urandom();
               qd = $urandom();
            end
            NEAR_ORIGIN: begin
               ip = $urandom_range(256) - 128;
               qd = $urandom_range(256) - 128;
            end
            SCALED_DOWN: begin
               ip = $signed($urandom()) >>> $urandom_range(31);
               qd = $signed($urandom()) >>> $urandom_range(31);
            end
            default: begin
               case ($urandom_range(2))
                  0:       rail = 32'sh0000_0000;
                  1:       rail = 32'sh8000_0000;
                  default: rail = 32'sh7fff_ffff;
               endcase
               if ($urandom_range(1)) begin
                  ip = rail;
                  qd = $urandom();
               end else begin
                  ip = $urandom();
                  qd = rail;
               end
            end
         endcase
         queue_sample(ip, qd);
      end
      total = samples_to_send.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every item to be accepted and every prediction to be matched.
      // Then let the pipeline run empty, so that a stray extra result still shows up.
      while (items_accepted < total)
         @(posedge clock);
      while (polar_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && polar_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
hw/rtl/iqmp_pkg.sv
hw/rtl/iq_to_magnitude_phase.sv
hw/rtl/iqmp_checker.sv
verif/tb_iq_to_magnitude_phase.sv
